[rtl/i2c7s_pkg.sv]
// ----------------------------------------------------------------------------
// i2c7s_pkg
// Shared types, constants and lookup functions of the seven-segment scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c7s_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int MAX_DIGITS     = 5;
    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int SEG_W          = 7;
    localparam int EN_W           = 4;
    localparam int DIGIT_W        = 4;
    localparam int POS_W          = 3;
    localparam int RECIP_W        = 17;
    localparam int SHIFT_W        = 5;
    localparam int PROD_W         = WORD_W + RECIP_W;
    localparam int DIV10_PROD_W   = 2 * WORD_W;
    localparam int APB_ADDR_W     = 2;
    localparam int APB_DATA_W     = 32;

    localparam logic [WORD_W-1:0]     DIV10_MULT  = 16'd52429;
    localparam logic [SHIFT_W-1:0]    DIV10_SHIFT = 5'd19;
    localparam logic [DIGIT_W-1:0]    RADIX       = 4'd10;

    localparam logic [APB_ADDR_W-1:0] ADDR_INVERT_SEGMENTS = 2'd0;

    typedef enum logic
    {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t        kind;
        logic [BYTE_W-1:0] rx_byte;
    } scan_in_t;

    typedef struct packed
    {
        logic [SEG_W-1:0] segments;
        logic [EN_W-1:0]  digit_enable;
    } scan_out_t;

    // Reciprocal of the power of ten for each digit position. The product
    // shifted right gives the exact quotient for every 16-bit word.
    function automatic logic [RECIP_W-1:0] recip_mult(input logic [POS_W-1:0] pos);
        logic [RECIP_W-1:0] m;
        begin
            unique case (pos)
                3'd0:    m = 17'd1;
                3'd1:    m = 17'd52429;
                3'd2:    m = 17'd83887;
                3'd3:    m = 17'd67109;
                3'd4:    m = 17'd107375;
                default: m = 17'd0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [SHIFT_W-1:0] recip_shift(input logic [POS_W-1:0] pos);
        logic [SHIFT_W-1:0] s;
        begin
            unique case (pos)
                3'd0:    s = 5'd0;
                3'd1:    s = 5'd19;
                3'd2:    s = 5'd23;
                3'd3:    s = 5'd26;
                3'd4:    s = 5'd30;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Segment a is bit 6, segment g is bit 0.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] p;
        begin
            unique case (digit)
                4'd0:    p = 7'b1111110;
                4'd1:    p = 7'b0110000;
                4'd2:    p = 7'b1101101;
                4'd3:    p = 7'b1111001;
                4'd4:    p = 7'b0110011;
                4'd5:    p = 7'b1011011;
                4'd6:    p = 7'b1011111;
                4'd7:    p = 7'b1110000;
                4'd8:    p = 7'b1111111;
                4'd9:    p = 7'b1111011;
                default: p = 7'b0000000;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/i2c_word_seven_segment_scanner.sv]
// Pipeline: a tick transaction passes in turn through the snapshot, quotient
// and result registers before it shows on out_valid; byte transactions give
// no result. One transaction per cycle unless out_ready stalls, set by the
// three registers (snapshot, quotient multiply, remainder and segment decode).
// Reset: rst_n is asynchronous and clears the word, the byte phase, the scan
// position, the invert register and all valid flags.
// ----------------------------------------------------------------------------
// i2c_word_seven_segment_scanner
// Assembles a 16-bit display word from received bytes and returns the segment
// pattern and digit enable of one decimal digit for each scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_word_seven_segment_scanner #(
    parameter int DIGITS = i2c7s_pkg::DIGITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire i2c7s_pkg::scan_in_t                  in_data,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output i2c7s_pkg::scan_out_t                      out_data,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [i2c7s_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [i2c7s_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [i2c7s_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready
);

    import i2c7s_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

    logic                  invert_reg,   invert_next;
    logic [WORD_W-1:0]     word_reg,     word_next;
    logic [BYTE_W-1:0]     held_reg,     held_next;
    logic                  phase_reg,    phase_next;
    logic [IDX_W-1:0]      idx_reg,      idx_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [WORD_W-1:0]     s1_word_reg;
    logic [IDX_W-1:0]      s1_pos_reg;
    logic                  s1_inv_reg;

    logic                  s2_valid_reg, s2_valid_next;
    logic [WORD_W-1:0]     s2_q_reg;
    logic [IDX_W-1:0]      s2_pos_reg;
    logic                  s2_inv_reg;

    logic                  out_valid_reg, out_valid_next;
    scan_out_t             out_data_reg;

    logic                  in_fire;
    logic                  tick_fire;
    logic                  byte_fire;
    logic                  out_free;
    logic                  s2_free;
    logic                  s1_free;
    logic                  cfg_write;

    logic [PROD_W-1:0]       quot_prod;
    logic [WORD_W-1:0]       quot_calc;
    logic [DIV10_PROD_W-1:0] div10_prod;
    logic [WORD_W-1:0]       div10_calc;
    logic [WORD_W-1:0]       rem_calc;
    logic [DIGIT_W-1:0]      digit_calc;
    scan_out_t               result_calc;

    assign out_free  = !out_valid_reg || out_ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_ready  = s1_free;
    assign in_fire   = in_valid && in_ready;
    assign tick_fire = in_fire && (in_data.kind == KIND_TICK);
    assign byte_fire = in_fire && (in_data.kind == KIND_BYTE);

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_INVERT_SEGMENTS) ?
                       APB_DATA_W'(invert_reg) : '0;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        invert_next = invert_reg;
        word_next   = word_reg;
        held_next   = held_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;

        if (cfg_write && (paddr == ADDR_INVERT_SEGMENTS))
        begin
            invert_next = pwdata[0];
        end

        if (byte_fire)
        begin
            if (!phase_reg)
            begin
                held_next  = in_data.rx_byte;
                phase_next = 1'b1;
            end
            else
            begin
                word_next  = {held_reg, in_data.rx_byte};
                phase_next = 1'b0;
            end
        end

        if (tick_fire)
        begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end

        s1_valid_next  = tick_fire || (s1_valid_reg && !s2_free);
        s2_valid_next  = (s1_valid_reg && s2_free) || (s2_valid_reg && !out_free);
        out_valid_next = (s2_valid_reg && out_free) || (out_valid_reg && !out_ready);
    end

    always_comb
    begin
        quot_prod  = PROD_W'(s1_word_reg) * PROD_W'(recip_mult(POS_W'(s1_pos_reg)));
        quot_calc  = WORD_W'(quot_prod >> recip_shift(POS_W'(s1_pos_reg)));

        div10_prod = DIV10_PROD_W'(s2_q_reg) * DIV10_PROD_W'(DIV10_MULT);
        div10_calc = WORD_W'(div10_prod >> DIV10_SHIFT);
        rem_calc   = s2_q_reg - ((div10_calc << 3) + (div10_calc << 1));
        digit_calc = rem_calc[DIGIT_W-1:0];

        result_calc.segments = seg_pattern(digit_calc) ^ {SEG_W{s2_inv_reg}};
        if (POS_W'(s2_pos_reg) < POS_W'(EN_W))
        begin
            result_calc.digit_enable = EN_W'(1'b1) << s2_pos_reg;
        end
        else
        begin
            result_calc.digit_enable = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg    <= 1'b0;
            word_reg      <= '0;
            held_reg      <= '0;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            invert_reg    <= invert_next;
            word_reg      <= word_next;
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_word_reg <= word_reg;
            s1_pos_reg  <= idx_reg;
            s1_inv_reg  <= invert_reg;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_q_reg   <= quot_calc;
            s2_pos_reg <= s1_pos_reg;
            s2_inv_reg <= s1_inv_reg;
        end
        if (s2_valid_reg && out_free)
        begin
            out_data_reg <= result_calc;
        end
    end

    scan_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("Scan position ran past the last digit.");

    second_byte_builds_word: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && phase_reg |=> word_reg == {$past(held_reg), $past(in_data.rx_byte)})
        else $error("Second byte did not complete the display word.");

    byte_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire |=> $stable(idx_reg))
        else $error("A byte transaction moved the scan position.");

    remainder_is_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> digit_calc < RADIX)
        else $error("Decimal digit extraction gave a value above nine.");

    result_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(out_data_reg.digit_enable))
        else $error("Digit enable of a result is not one-hot.");

endmodule

`default_nettype wire
